@@ rtl/core/hhlf_pkg.sv @@
`default_nettype none

package hhlf_pkg;

    localparam int CFG_BITS    = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] LINES_MAX = 8'hFF;
    localparam logic [CFG_BITS-1:0] END_LINE_LENGTH = 16'd2;

    typedef enum logic [3:0] {
        ST_SCAN       = 4'd0,
        ST_LINE       = 4'd1,
        ST_DONE       = 4'd2,
        ST_INCOMPLETE = 4'd3,
        ST_NO_CR      = 4'd4,
        ST_SHORT      = 4'd5,
        ST_URI_LONG   = 4'd6,
        ST_FIELDS     = 4'd7,
        ST_TOO_LARGE  = 4'd8
    } t_status;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MIN_LINE_LENGTH    = 3'd0,
        CFG_MAX_REQ_LINE_LEN   = 3'd1,
        CFG_MAX_HEADER_LINES   = 3'd2,
        CFG_MAX_HEADER_LINE_LEN = 3'd3,
        CFG_MAX_REQUEST_BYTES  = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [15:0] min_line_length;
        logic [15:0] max_request_line_length;
        logic [7:0]  max_header_lines;
        logic [15:0] max_header_line_length;
        logic [15:0] max_request_bytes;
    } t_cfg;

    typedef struct packed {
        logic is_lf;
        logic is_cr;
        logic first;
        logic last;
    } t_item;

endpackage

`default_nettype wire

@@ rtl/core/hhlf_front.sv @@
`default_nettype none

module hhlf_front
    import hhlf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_first_byte,
    input  wire logic       i_last_available,
    input  wire logic       i_queue_full,
    output logic            o_push,
    output t_item           o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  accept;

    assign o_push     = r_valid && !i_queue_full;
    assign o_in_ready = !r_valid || !i_queue_full;
    assign accept     = i_in_valid && o_in_ready;
    assign n_valid    = accept || (r_valid && !o_push);
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // classify the byte on the way in
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.is_lf <= (i_data_byte == CHAR_LF);
            r_item.is_cr <= (i_data_byte == CHAR_CR);
            r_item.first <= i_first_byte;
            r_item.last  <= i_last_available;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/hhlf_queue.sv @@
`default_nettype none

module hhlf_queue
    import hhlf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    output logic       o_valid,
    input  wire logic  i_pop,
    output t_item      o_item
);

    t_item                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wptr;
    logic [QPTR_BITS-1:0] r_rptr;
    logic [QCNT_BITS-1:0] r_count;
    logic                 pop_ok;

    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop_ok) begin
                r_rptr <= (r_rptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + QCNT_BITS'(i_push) - QCNT_BITS'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/hhlf_back.sv @@
`default_nettype none

module hhlf_back
    import hhlf_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_item_valid,
    input  wire t_item i_item,
    output logic       o_pop,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output logic [3:0]  o_parse_status,
    output logic [15:0] o_line_end_offset,
    output logic [7:0]  o_line_index,
    output logic [15:0] o_line_length
);

    localparam int CW = ((POSITION_BITS > CFG_BITS) ? POSITION_BITS : CFG_BITS) + 1;

    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] r_prev_lf;
    logic                     r_prev_cr;
    logic [7:0]               r_lines;
    t_status                  r_term;

    logic [POSITION_BITS-1:0] n_pos;
    logic [POSITION_BITS-1:0] n_prev_lf;
    logic                     n_prev_cr;
    logic [7:0]               n_lines;
    t_status                  n_term;

    logic                     r_out_valid;
    t_status                  r_status;
    logic [CW-1:0]            r_end_off;
    logic [7:0]               r_index;
    logic [CW-1:0]            r_len;

    t_status                  n_status;
    logic [CW-1:0]            n_end_off;
    logic [7:0]               n_index;
    logic [CW-1:0]            n_len;

    logic [POSITION_BITS-1:0] cur_pos;
    logic [POSITION_BITS-1:0] cur_prev_lf;
    logic                     cur_prev_cr;
    logic [7:0]               cur_lines;
    t_status                  cur_term;
    logic [POSITION_BITS-1:0] len_raw;
    logic [CW-1:0]            len_ext;
    logic [CW-1:0]            pos_next_ext;
    logic [7:0]               lines_inc;
    logic                     line_end;
    t_status                  lf_status;
    logic                     terminal;

    assign o_pop = i_item_valid && (!r_out_valid || i_out_ready);

    // state as seen by this beat, after a first byte clears it
    always_comb begin
        cur_pos     = i_item.first ? '0 : r_pos;
        cur_prev_lf = i_item.first ? '0 : r_prev_lf;
        cur_prev_cr = i_item.first ? 1'b0 : r_prev_cr;
        cur_lines   = i_item.first ? '0 : r_lines;
        cur_term    = i_item.first ? ST_SCAN : r_term;
    end

    assign len_raw      = (cur_lines == '0) ? cur_pos : cur_pos - cur_prev_lf;
    assign len_ext      = CW'(len_raw);
    assign pos_next_ext = CW'(cur_pos) + CW'(1);
    assign lines_inc    = (cur_lines == LINES_MAX) ? LINES_MAX : cur_lines + 8'd1;
    assign line_end     = i_item.is_lf && cur_prev_cr;

    always_comb begin
        priority if (len_ext > CW'(END_LINE_LENGTH)
                     && len_ext < CW'(i_cfg.min_line_length)) begin
            lf_status = ST_SHORT;
        end else if (lines_inc == 8'd1 && len_ext > CW'(i_cfg.max_request_line_length)) begin
            lf_status = ST_URI_LONG;
        end else if (lines_inc > 8'd1 && (lines_inc > i_cfg.max_header_lines
                     || len_ext > CW'(i_cfg.max_header_line_length))) begin
            lf_status = ST_FIELDS;
        end else if (len_ext == CW'(END_LINE_LENGTH)) begin
            lf_status = ST_DONE;
        end else begin
            lf_status = ST_LINE;
        end
    end

    always_comb begin
        n_pos     = r_pos;
        n_prev_lf = r_prev_lf;
        n_prev_cr = r_prev_cr;
        n_lines   = r_lines;
        n_term    = r_term;
        n_status  = cur_term;
        n_end_off = '0;
        n_index   = '0;
        n_len     = '0;
        if (cur_term == ST_SCAN) begin
            n_status = ST_SCAN;
            n_lines   = cur_lines;
            n_prev_lf = cur_prev_lf;
            if (i_item.is_lf) begin
                if (!line_end) begin
                    n_status = ST_NO_CR;
                end else begin
                    n_status  = lf_status;
                    n_lines   = lines_inc;
                    n_prev_lf = cur_pos;
                    n_end_off = CW'(cur_pos);
                    n_index   = lines_inc;
                    n_len     = len_ext;
                end
            end
            if (n_status == ST_SCAN || n_status == ST_LINE) begin
                if (pos_next_ext >= CW'(i_cfg.max_request_bytes)) begin
                    n_status = ST_TOO_LARGE;
                end else if (i_item.last) begin
                    n_status = ST_INCOMPLETE;
                end
            end
            n_prev_cr = i_item.is_cr;
            n_pos     = cur_pos + 1'b1;
            terminal  = (n_status != ST_SCAN) && (n_status != ST_LINE)
                        && (n_status != ST_INCOMPLETE);
            n_term    = terminal ? n_status : ST_SCAN;
        end else begin
            terminal = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_prev_lf   <= '0;
            r_prev_cr   <= 1'b0;
            r_lines     <= '0;
            r_term      <= ST_SCAN;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pos     <= n_pos;
                r_prev_lf <= n_prev_lf;
                r_prev_cr <= n_prev_cr;
                r_lines   <= n_lines;
                r_term    <= n_term;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status  <= n_status;
            r_end_off <= n_end_off;
            r_index   <= n_index;
            r_len     <= n_len;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_parse_status    = r_status;
    assign o_line_end_offset = r_end_off[15:0];
    assign o_line_index      = r_index;
    assign o_line_length     = r_len[15:0];

endmodule

`default_nettype wire

@@ rtl/core/http_header_line_framer.sv @@
// channel  direction  handshake                     payload
// in       input      i_in_valid / o_in_ready       i_data_byte, i_first_byte, i_last_available
// out      output     o_out_valid / i_out_ready     o_parse_status, o_line_end_offset,
//                                                   o_line_index, o_line_length
// cfg      input      i_cfg_we (no wait)            i_cfg_index, i_cfg_data
//
// one byte per cycle sustained while the output is not stalled; a taken byte's result
// passes the input register, the two-entry queue and the output register
// the back end updates the line state in one registered step per popped byte
// reset is synchronous and active low; it clears line state and loads the limit defaults
// output stalls fill the queue, then drop o_in_ready; no beat is lost or repeated
`default_nettype none

module http_header_line_framer
    import hhlf_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [7:0]               i_data_byte,
    input  wire logic                     i_first_byte,
    input  wire logic                     i_last_available,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [3:0]                    o_parse_status,
    output logic [15:0]                   o_line_end_offset,
    output logic [7:0]                    o_line_index,
    output logic [15:0]                   o_line_length,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_BITS-1:0]      i_cfg_data
);

    t_cfg  r_cfg;
    logic  q_full;
    logic  q_push;
    t_item f_item;
    logic  q_valid;
    logic  q_pop;
    t_item q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_line_length         <= 16'd4;
            r_cfg.max_request_line_length <= 16'd2048;
            r_cfg.max_header_lines        <= 8'd64;
            r_cfg.max_header_line_length  <= 16'd4096;
            r_cfg.max_request_bytes       <= 16'd8192;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MIN_LINE_LENGTH:     r_cfg.min_line_length         <= i_cfg_data;
                CFG_MAX_REQ_LINE_LEN:    r_cfg.max_request_line_length <= i_cfg_data;
                CFG_MAX_HEADER_LINES:    r_cfg.max_header_lines        <= i_cfg_data[7:0];
                CFG_MAX_HEADER_LINE_LEN: r_cfg.max_header_line_length  <= i_cfg_data;
                CFG_MAX_REQUEST_BYTES:   r_cfg.max_request_bytes       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    hhlf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_first_byte     (i_first_byte),
        .i_last_available (i_last_available),
        .i_queue_full     (q_full),
        .o_push           (q_push),
        .o_item           (f_item)
    );

    hhlf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (f_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    hhlf_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_item_valid      (q_valid),
        .i_item            (q_item),
        .o_pop             (q_pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_parse_status    (o_parse_status),
        .o_line_end_offset (o_line_end_offset),
        .o_line_index      (o_line_index),
        .o_line_length     (o_line_length)
    );

endmodule

`default_nettype wire
